### sv/ofp_pkg.sv
// Shared types and constants of the oil paint filter.
`default_nettype none

package ofp_pkg;

   // Job fields are sized for the largest line store the parameters allow
   localparam int SLOT_W = 5;
   localparam int COL_W  = 13;

   // Luminance weights, result taken from bit LUMA_SHIFT upward
   localparam logic [11:0] LUMA_R     = 12'd871;
   localparam logic [11:0] LUMA_G     = 12'd2929;
   localparam logic [11:0] LUMA_B     = 12'd295;
   localparam int          LUMA_SHIFT = 12;

   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      CSR_RADIUS = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   // One output pixel to produce: centre row slot, window column, border and last flags
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [COL_W-1:0]  col;
      logic              border;
      logic              last;
   } job_type;

endpackage

`default_nettype wire

### sv/oil_paint_filter_rgb_top.sv
// Top level of the RGB oil paint filter with its register port.
`default_nettype none

// RGB oil paint filter. Pixels enter in raster order and each result is the
// pixel radius rows above, replaced by the colour of the neighbour whose
// luminance is most frequent in its diamond window; pixels within radius of
// a border pass unchanged, and drain transactions flush the final rows once
// the frame is in. An interior result visits the 2*r*r + 2*r + 1 pixels of
// its diamond, one window visit per cycle through the one read port of the
// luminance histogram; a border result only fetches its centre pixel.
// The first pixel of each input row waits until all pending windows are
// finished, since the new row may reuse a line store slot. Registers:
// radius at 0x0, image width at 0x4, image height at 0x8; a write restarts
// the frame.
module oil_paint_filter_rgb_top import ofp_pkg::*; #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_RADIUS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic                  req_kind,
   input  wire logic [7:0]            req_red_in,
   input  wire logic [7:0]            req_green_in,
   input  wire logic [7:0]            req_blue_in,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic      [7:0]            rsp_red_out,
   output logic      [7:0]            rsp_green_out,
   output logic      [7:0]            rsp_blue_out,
   output logic                       rsp_frame_end,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int AW = $clog2(STORE_ROWS * MAX_WIDTH);

   logic [3:0]    radius_ff;
   logic [11:0]   width_ff;
   logic [15:0]   height_ff;
   logic          csr_write;
   csr_index_type csr_index;
   logic          cfg_clear;
   logic [3:0]    radius_eff;
   logic [WW-1:0] width_eff;
   logic [15:0]   height_eff;

   logic          ls_we;
   logic [AW-1:0] ls_waddr;
   logic [23:0]   ls_wdata;
   logic [AW-1:0] ls_raddr;
   logic [23:0]   ls_rdata;
   logic          job_push;
   job_type       push_job;
   job_type       job_head;
   logic          q_full;
   logic          q_empty;
   logic          job_pop;
   logic          back_active;
   logic          back_busy;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      case (csr_index)
         CSR_RADIUS: begin
            csr_prdata = 32'(radius_ff);
            cfg_clear  = csr_write;
         end
         CSR_WIDTH: begin
            csr_prdata = 32'(width_ff);
            cfg_clear  = csr_write;
         end
         CSR_HEIGHT: begin
            csr_prdata = 32'(height_ff);
            cfg_clear  = csr_write;
         end
         default: begin
            csr_prdata = 32'd0;
            cfg_clear  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 4'd3;
         width_ff  <= 12'd640;
         height_ff <= 16'd480;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_pwdata[3:0];
            CSR_WIDTH:  width_ff  <= csr_pwdata[11:0];
            CSR_HEIGHT: height_ff <= csr_pwdata[15:0];
            default:    radius_ff <= radius_ff;
         endcase
      end
   end

   // Clamp the settings to what the line store supports
   assign radius_eff = (radius_ff > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : radius_ff;
   assign height_eff = (height_ff == 16'd0) ? 16'd1 : height_ff;
   always_comb begin
      if (width_ff == 12'd0) begin
         width_eff = WW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(width_ff);
      end
   end

   assign back_busy = back_active || !q_empty;

   ofp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .kind      (req_kind),
      .red       (req_red_in),
      .green     (req_green_in),
      .blue      (req_blue_in),
      .radius    (radius_eff),
      .width     (width_eff),
      .height    (height_eff),
      .cfg_clear (cfg_clear),
      .back_busy (back_busy),
      .q_full    (q_full),
      .ls_we     (ls_we),
      .ls_waddr  (ls_waddr),
      .ls_wdata  (ls_wdata),
      .job_push  (job_push),
      .job       (push_job)
   );

   ofp_ram #(
      .WIDTH (24),
      .DEPTH (STORE_ROWS * MAX_WIDTH)
   ) u_line_store (
      .clock (clock),
      .we    (ls_we),
      .waddr (ls_waddr),
      .wdata (ls_wdata),
      .raddr (ls_raddr),
      .rdata (ls_rdata)
   );

   ofp_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (job_pop),
      .empty    (q_empty),
      .head     (job_head)
   );

   ofp_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .radius        (radius_eff),
      .job_empty     (q_empty),
      .job_head      (job_head),
      .job_pop       (job_pop),
      .ls_raddr      (ls_raddr),
      .ls_rdata      (ls_rdata),
      .busy          (back_active),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_red       (rsp_red_out),
      .rsp_green     (rsp_green_out),
      .rsp_blue      (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

### sv/ofp_ram.sv
// Generic simple dual port RAM with registered read.
`default_nettype none

module ofp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and read; a read of the address being written returns the old word
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### sv/ofp_jobq.sv
// Two-entry job queue between the front and the back of the filter.
`default_nettype none

module ofp_jobq import ofp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output job_type      head
);

   job_type    entry_ff [2];
   logic       wptr_ff;
   logic       rptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = entry_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Store jobs
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_job;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wptr_ff <= !wptr_ff;
         end
         if (do_pop) begin
            rptr_ff <= !rptr_ff;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

### sv/ofp_front.sv
// Front of the filter: takes transactions, fills the line store, issues jobs.
`default_nettype none

module ofp_front import ofp_pkg::*; #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_RADIUS = 10,
   localparam int STORE_ROWS = 2 * MAX_RADIUS + 1,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int AW = $clog2(STORE_ROWS * MAX_WIDTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   output logic               full,
   input  wire logic          kind,
   input  wire logic [7:0]    red,
   input  wire logic [7:0]    green,
   input  wire logic [7:0]    blue,
   input  wire logic [3:0]    radius,
   input  wire logic [WW-1:0] width,
   input  wire logic [15:0]   height,
   input  wire logic          cfg_clear,
   input  wire logic          back_busy,
   input  wire logic          q_full,
   output logic               ls_we,
   output logic      [AW-1:0] ls_waddr,
   output logic      [23:0]   ls_wdata,
   output logic               job_push,
   output job_type            job
);

   localparam int SW = $clog2(STORE_ROWS);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int CX = WW + 1;
   localparam logic [SW-1:0] LAST_SLOT  = SW'(STORE_ROWS - 1);
   localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

   logic [CW-1:0] in_col_ff,  in_col_in;
   logic [15:0]   in_row_ff,  in_row_in;
   logic [SW-1:0] in_slot_ff, in_slot_in;
   logic [CW-1:0] out_col_ff,  out_col_in;
   logic [15:0]   out_row_ff,  out_row_in;
   logic [SW-1:0] out_slot_ff, out_slot_in;

   logic          rows_in;
   logic          accept;
   logic          is_write;
   logic          emits;
   logic [CX-1:0] in_col_next;
   logic [CX-1:0] out_col_next;
   logic          in_wrap;
   logic          out_wrap;
   logic          last;
   logic          border;

   // Classify the transaction
   assign rows_in  = in_row_ff < height;
   // A new input row may overwrite a slot that a pending window still reads
   assign full     = q_full || (rows_in && (in_col_ff == '0) && back_busy);
   assign accept   = push && !full;
   assign is_write = accept && rows_in && !kind;
   assign emits    = !rows_in || (!kind && (in_row_ff >= 16'(radius)));
   assign job_push = accept && emits;

   // Line store write
   assign ls_we    = is_write;
   assign ls_waddr = AW'(in_slot_ff) * ROW_STRIDE + AW'(in_col_ff);
   assign ls_wdata = {red, green, blue};

   // Position bookkeeping
   assign in_col_next  = CX'(in_col_ff) + CX'(1);
   assign out_col_next = CX'(out_col_ff) + CX'(1);
   assign in_wrap      = in_col_next >= CX'(width);
   assign out_wrap     = out_col_next >= CX'(width);
   assign last         = ((17'(out_row_ff) + 17'd1) >= 17'(height)) && out_wrap;
   assign border       = (CX'(out_col_ff) < CX'(radius))
                      || ((CX'(out_col_ff) + CX'(radius)) >= CX'(width))
                      || (out_row_ff < 16'(radius))
                      || ((17'(out_row_ff) + 17'(radius)) >= 17'(height));

   assign job.slot   = SLOT_W'(out_slot_ff);
   assign job.col    = COL_W'(out_col_ff);
   assign job.border = border;
   assign job.last   = last;

   // Next counter values
   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      if (is_write) begin
         if (in_wrap) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + 16'd1;
            in_slot_in = (in_slot_ff == LAST_SLOT) ? '0 : in_slot_ff + SW'(1);
         end else begin
            in_col_in = CW'(in_col_next);
         end
      end
      if (job_push) begin
         if (out_wrap) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + 16'd1;
            out_slot_in = (out_slot_ff == LAST_SLOT) ? '0 : out_slot_ff + SW'(1);
         end else begin
            out_col_in = CW'(out_col_next);
         end
      end
      // End of frame or a register write starts over
      if (cfg_clear || (job_push && last)) begin
         in_col_in   = '0;
         in_row_in   = '0;
         in_slot_in  = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         out_slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
      end
   end

endmodule

`default_nettype wire

### sv/ofp_back.sv
// Back of the filter: scans each interior window through the luminance histogram.
`default_nettype none

module ofp_back import ofp_pkg::*; #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_RADIUS = 10,
   localparam int STORE_ROWS = 2 * MAX_RADIUS + 1,
   localparam int AW = $clog2(STORE_ROWS * MAX_WIDTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [3:0]    radius,
   input  wire logic          job_empty,
   input  wire job_type       job_head,
   output logic               job_pop,
   output logic      [AW-1:0] ls_raddr,
   input  wire logic [23:0]   ls_rdata,
   output logic               busy,
   input  wire logic          rsp_pop,
   output logic               rsp_empty,
   output logic      [7:0]    rsp_red,
   output logic      [7:0]    rsp_green,
   output logic      [7:0]    rsp_blue,
   output logic               rsp_frame_end
);

   localparam int SW = $clog2(STORE_ROWS);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam logic [SW:0]   ROWS_X     = (SW + 1)'(STORE_ROWS);
   localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CENTER,
      ST_FLUSH,
      ST_DONE
   } state_type;

   state_type   state_ff;
   job_type     job_ff;
   logic [3:0]  gi_ff;
   logic [4:0]  gj_ff;
   logic        glow_ff;
   logic        gmid_ff;

   logic        v1_ff, c1_ff;
   logic        v2_ff;
   logic [7:0]  k2_ff;
   logic [23:0] pix2_ff;
   logic        v3_ff;
   logic [7:0]  k3_ff;
   logic [23:0] pix3_ff;
   logic        v4_ff;
   logic [7:0]  k4_ff;
   logic [7:0]  n4_ff;
   logic [255:0] hv_ff;
   logic [7:0]  best_cnt_ff;
   logic [23:0] best_pix_ff;
   logic        out_valid_ff;
   logic [23:0] out_pix_ff;
   logic        out_last_ff;

   logic [3:0]    row_gap;
   logic [SW:0]   s_x;
   logic [SW:0]   d_x;
   logic [SW:0]   up_slot;
   logic [SW:0]   lo_sum;
   logic [SW:0]   lo_slot;
   logic [SW-1:0] row_slot;
   logic [CW:0]   col_x;
   logic          issue;
   logic          scan_end;
   logic [19:0]   luma_sum;
   logic [7:0]    h_rd;
   logic [7:0]    cnt_old;
   logic [7:0]    cnt_new;
   logic          out_free;

   // Window address generation
   assign row_gap = radius - gi_ff;
   assign s_x     = (SW + 1)'(job_ff.slot);
   assign d_x     = (SW + 1)'(row_gap);
   assign up_slot = (s_x >= d_x) ? s_x - d_x : s_x + ROWS_X - d_x;
   assign lo_sum  = s_x + d_x;
   assign lo_slot = (lo_sum >= ROWS_X) ? lo_sum - ROWS_X : lo_sum;

   always_comb begin
      if (state_ff == ST_CENTER || gmid_ff) begin
         row_slot = SW'(s_x);
      end else if (glow_ff) begin
         row_slot = SW'(lo_slot);
      end else begin
         row_slot = SW'(up_slot);
      end
      if (state_ff == ST_CENTER) begin
         col_x = (CW + 1)'(job_ff.col);
      end else if (gmid_ff) begin
         col_x = (CW + 1)'(job_ff.col) + (CW + 1)'(gj_ff) - (CW + 1)'(radius);
      end else begin
         col_x = (CW + 1)'(job_ff.col) + (CW + 1)'(gj_ff) - (CW + 1)'(gi_ff);
      end
   end

   assign ls_raddr = AW'(row_slot) * ROW_STRIDE + AW'(col_x[CW-1:0]);
   assign issue    = (state_ff == ST_SCAN) || (state_ff == ST_CENTER);
   assign scan_end = gmid_ff && (gj_ff == {radius, 1'b0});

   assign job_pop   = (state_ff == ST_IDLE) && !job_empty;
   assign busy      = (state_ff != ST_IDLE);
   assign out_free  = !out_valid_ff || rsp_pop;

   // Luminance of the fetched pixel
   assign luma_sum = 20'(ls_rdata[23:16]) * 20'(LUMA_R)
                   + 20'(ls_rdata[15:8]) * 20'(LUMA_G)
                   + 20'(ls_rdata[7:0]) * 20'(LUMA_B);

   // Histogram count with forwarding of the write still in flight
   always_comb begin
      if (v4_ff && (k4_ff == k3_ff)) begin
         cnt_old = n4_ff;
      end else if (hv_ff[k3_ff]) begin
         cnt_old = h_rd;
      end else begin
         cnt_old = 8'd0;
      end
      cnt_new = cnt_old + 8'd1;
   end

   ofp_ram #(
      .WIDTH (8),
      .DEPTH (256)
   ) u_hist (
      .clock (clock),
      .we    (v3_ff),
      .waddr (k3_ff),
      .wdata (cnt_new),
      .raddr (k2_ff),
      .rdata (h_rd)
   );

   // Sequencer, window generator and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gi_ff        <= '0;
         gj_ff        <= '0;
         glow_ff      <= 1'b0;
         gmid_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // Load the result register when free, drop the result once taken
         if (state_ff == ST_DONE && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!job_empty) begin
                  gi_ff    <= '0;
                  gj_ff    <= '0;
                  glow_ff  <= 1'b0;
                  gmid_ff  <= (radius == 4'd0);
                  state_ff <= job_head.border ? ST_CENTER : ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (gmid_ff) begin
                  if (scan_end) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     gj_ff <= gj_ff + 5'd1;
                  end
               end else if (!glow_ff) begin
                  glow_ff <= 1'b1;
               end else begin
                  glow_ff <= 1'b0;
                  if (gj_ff == {gi_ff, 1'b0}) begin
                     gj_ff <= '0;
                     if ((gi_ff + 4'd1) == radius) begin
                        gmid_ff <= 1'b1;
                     end else begin
                        gi_ff <= gi_ff + 4'd1;
                     end
                  end else begin
                     gj_ff <= gj_ff + 5'd1;
                  end
               end
            end
            ST_CENTER: begin
               state_ff <= ST_FLUSH;
            end
            ST_FLUSH: begin
               if (!v1_ff && !v2_ff && !v3_ff) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Hold the job and the result payload
   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_head;
      end
      if (state_ff == ST_DONE && out_free) begin
         out_pix_ff  <= best_pix_ff;
         out_last_ff <= job_ff.last;
      end
   end

   // Visit pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         c1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         hv_ff <= '0;
      end else begin
         v1_ff <= issue;
         c1_ff <= (state_ff == ST_CENTER);
         v2_ff <= v1_ff && !c1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (job_pop) begin
            hv_ff <= '0;
         end else if (v3_ff) begin
            hv_ff[k3_ff] <= 1'b1;
         end
      end
   end

   // Visit pipeline data and running winner
   always_ff @(posedge clock) begin
      k2_ff   <= luma_sum[LUMA_SHIFT +: 8];
      pix2_ff <= ls_rdata;
      k3_ff   <= k2_ff;
      pix3_ff <= pix2_ff;
      k4_ff   <= k3_ff;
      n4_ff   <= cnt_new;
      if (job_pop) begin
         best_cnt_ff <= 8'd0;
      end else if (v1_ff && c1_ff) begin
         best_pix_ff <= ls_rdata;
      end else if (v3_ff && (cnt_new > best_cnt_ff)) begin
         best_cnt_ff <= cnt_new;
         best_pix_ff <= pix3_ff;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_red       = out_pix_ff[23:16];
   assign rsp_green     = out_pix_ff[15:8];
   assign rsp_blue      = out_pix_ff[7:0];
   assign rsp_frame_end = out_last_ff;

`ifndef ASSERT_OFF
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!v1_ff && !v2_ff && !v3_ff))
      else $error("window started with visits in flight");

   a_hist_write_in_window: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (state_ff == ST_SCAN || state_ff == ST_FLUSH))
      else $error("histogram written outside a window scan");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_valid_ff && !rsp_pop) |=> (state_ff == ST_DONE))
      else $error("result register overwritten while occupied");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (state_ff == ST_SCAN || state_ff == ST_CENTER))
      else $error("job taken without starting a scan");
`endif

endmodule

`default_nettype wire
